### rtl/core/npss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_pkg: shared types and constants
// Field widths, register codes and the records passed between the point
// pipeline, the side tracker and the result queue.
// ----------------------------------------------------------------------------
package npss_pkg;

  // Field widths
  localparam int COORD_W = 24;   // Q12.12 coordinates
  localparam int DIR_W   = 16;   // Q1.14 direction
  localparam int IDX_W   = 10;   // reported index
  localparam int OFS_W   = COORD_W + 1;        // exact offset from center
  localparam int PROD_W  = OFS_W + DIR_W - 1;  // offset times direction
  localparam int DOT_W   = PROD_W + 2;         // sum of three products
  localparam int SQ_W    = 2 * (OFS_W - 1);    // square of an offset
  localparam int DIST_W  = SQ_W + 2;           // sum of three squares

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd16384;

  // Pipeline occupancy and result queue sizing
  localparam int STAGES    = 4;
  localparam int INFL_W    = 3;
  localparam int OQ_DEPTH  = 8;
  localparam int OQ_PTR_W  = 3;
  localparam int OQ_CNT_W  = 4;

  // One classified point leaving the arithmetic pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              pos;
    logic [DIST_W-1:0] sqd;
  } npss_pt_t;

  // One slice result
  typedef struct packed {
    logic [IDX_W-1:0] pos_idx;
    logic             pos_found;
    logic [IDX_W-1:0] neg_idx;
    logic             neg_found;
  } npss_res_t;

endpackage
`default_nettype wire

### rtl/core/npss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_front: point arithmetic pipeline
// Holds the center and direction registers, and per point computes the
// offset, the dot product sign and the exact squared distance over four
// register stages.
// ----------------------------------------------------------------------------
module npss_front (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     cfg_we,
  input  wire        [npss_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire        [npss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                                     in_acc,
  input  wire signed [npss_pkg::COORD_W-1:0]      in_point_x,
  input  wire signed [npss_pkg::COORD_W-1:0]      in_point_y,
  input  wire signed [npss_pkg::COORD_W-1:0]      in_point_z,
  input  wire                                     in_last,
  output npss_pkg::npss_pt_t                      pt,
  output logic       [npss_pkg::INFL_W-1:0]       inflight
);
  import npss_pkg::*;

  // configuration registers
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic signed [DIR_W-1:0]   ux_r, uy_r, uz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      ux_r <= DIR_X_RST;
      uy_r <= '0;
      uz_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CENTER_X: cx_r <= cfg_data;
        REG_CENTER_Y: cy_r <= cfg_data;
        REG_CENTER_Z: cz_r <= cfg_data;
        REG_DIR_X:    ux_r <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    uy_r <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:    uz_r <= cfg_data[DIR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage valid bits
  logic s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r;
  logic s0_last_r, s1_last_r, s2_last_r, s3_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_acc;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // stage 0: input register
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r      <= in_point_x;
      py_r      <= in_point_y;
      pz_r      <= in_point_z;
      s0_last_r <= in_last;
    end
  end

  // stage 1: offsets from the center
  logic signed [OFS_W-1:0] dx, dy, dz;
  logic signed [OFS_W-1:0] dx_r, dy_r, dz_r;

  assign dx = px_r - cx_r;
  assign dy = py_r - cy_r;
  assign dz = pz_r - cz_r;

  always_ff @(posedge clk) begin
    dx_r      <= dx;
    dy_r      <= dy;
    dz_r      <= dz;
    s1_last_r <= s0_last_r;
  end

  // stage 2: direction products and squares
  logic signed [PROD_W-1:0] mx, my, mz;
  logic signed [PROD_W-1:0] mx_r, my_r, mz_r;
  logic signed [SQ_W+1:0]   qx, qy, qz;
  logic        [SQ_W-1:0]   qx_r, qy_r, qz_r;

  assign mx = dx_r * ux_r;
  assign my = dy_r * uy_r;
  assign mz = dz_r * uz_r;
  assign qx = dx_r * dx_r;
  assign qy = dy_r * dy_r;
  assign qz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    mx_r      <= mx;
    my_r      <= my;
    mz_r      <= mz;
    qx_r      <= qx[SQ_W-1:0];
    qy_r      <= qy[SQ_W-1:0];
    qz_r      <= qz[SQ_W-1:0];
    s2_last_r <= s1_last_r;
  end

  // stage 3: dot product sign and distance sum
  logic signed [DOT_W-1:0]  dot;
  logic        [DIST_W-1:0] sqd;
  logic                     pos_r;
  logic        [DIST_W-1:0] sqd_r;

  assign dot = mx_r + my_r + mz_r;
  assign sqd = DIST_W'(qx_r) + DIST_W'(qy_r) + DIST_W'(qz_r);

  always_ff @(posedge clk) begin
    pos_r     <= !dot[DOT_W-1] && (dot != '0);
    sqd_r     <= sqd;
    s3_last_r <= s2_last_r;
  end

  assign pt.vld  = s3_vld_r;
  assign pt.last = s3_last_r;
  assign pt.pos  = pos_r;
  assign pt.sqd  = sqd_r;

  // items held in the pipeline
  assign inflight = INFL_W'(s0_vld_r) + INFL_W'(s1_vld_r)
                  + INFL_W'(s2_vld_r) + INFL_W'(s3_vld_r);

endmodule
`default_nettype wire

### rtl/core/npss_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_track: per-side nearest point tracker
// Counts the points of a slice, keeps the nearest point on each side and
// forms the slice result when the last point arrives.
// ----------------------------------------------------------------------------
module npss_track #(
  parameter int MAX_POINTS = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  npss_pkg::npss_pt_t  pt,
  output logic                res_vld,
  output npss_pkg::npss_res_t res
);
  import npss_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIST_W-1:0] pbest_r, pbest_nxt, nbest_r, nbest_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt, nidx_r, nidx_nxt;
  logic              phave_r, phave_nxt, nhave_r, nhave_nxt;
  logic              fpos_r, fpos_nxt;
  logic              take, pupd, nupd;
  logic [IDX_W-1:0]  idx;

  // points past the limit are dropped but may still close the slice
  assign take = pt.vld && (cnt_r < CNT_MAX);
  assign idx  = IDX_W'(cnt_r);
  assign pupd = take && pt.pos && (!phave_r || (pt.sqd < pbest_r));
  assign nupd = take && !pt.pos && (!nhave_r || (pt.sqd < nbest_r));

  // next state before the slice closes
  always_comb begin
    cnt_nxt   = take ? cnt_r + CNT_ONE : cnt_r;
    pbest_nxt = pupd ? pt.sqd : pbest_r;
    pidx_nxt  = pupd ? idx : pidx_r;
    phave_nxt = phave_r | pupd;
    nbest_nxt = nupd ? pt.sqd : nbest_r;
    nidx_nxt  = nupd ? idx : nidx_r;
    nhave_nxt = nhave_r | nupd;
    fpos_nxt  = fpos_r | (take && pt.pos && (cnt_r == '0));
  end

  // slice result; one and two point slices follow the point order
  assign res_vld = pt.vld && pt.last;

  always_comb begin
    priority if (cnt_nxt == CNT_ONE) begin
      res.pos_idx   = '0;
      res.pos_found = 1'b1;
      res.neg_idx   = '0;
      res.neg_found = 1'b1;
    end else if (cnt_nxt == CNT_TWO) begin
      res.pos_idx   = fpos_nxt ? IDX_W'(0) : IDX_W'(1);
      res.pos_found = 1'b1;
      res.neg_idx   = fpos_nxt ? IDX_W'(1) : IDX_W'(0);
      res.neg_found = 1'b1;
    end else begin
      res.pos_idx   = phave_nxt ? pidx_nxt : '0;
      res.pos_found = phave_nxt;
      res.neg_idx   = nhave_nxt ? nidx_nxt : '0;
      res.neg_found = nhave_nxt;
    end
  end

  // control state: cleared when the slice closes
  always_ff @(posedge clk) begin
    if (!rst_n || res_vld) begin
      cnt_r   <= '0;
      phave_r <= 1'b0;
      nhave_r <= 1'b0;
      fpos_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      phave_r <= phave_nxt;
      nhave_r <= nhave_nxt;
      fpos_r  <= fpos_nxt;
    end
  end

  // best distance and index, qualified by the have flags
  always_ff @(posedge clk) begin
    pbest_r <= pbest_nxt;
    pidx_r  <= pidx_nxt;
    nbest_r <= nbest_nxt;
    nidx_r  <= nidx_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/npss_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_outq: result queue
// Small register queue that holds slice results until the output side
// takes them, so the point pipeline keeps moving during output stalls.
// ----------------------------------------------------------------------------
module npss_outq (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              push,
  input  npss_pkg::npss_res_t              push_data,
  input  wire                              pop,
  output npss_pkg::npss_res_t              head,
  output logic                             head_vld,
  output logic [npss_pkg::OQ_CNT_W-1:0]    cnt
);
  import npss_pkg::*;

  npss_res_t             mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0]   cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + OQ_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - OQ_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head     = mem_r[rd_ptr_r];
  assign head_vld = (cnt_r != '0);
  assign cnt      = cnt_r;

endmodule
`default_nettype wire

### rtl/core/nearest_point_per_side_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_per_side_select: nearest point per cut side
// Streams the points of a slice, splits them by the sign of their offset
// dotted with the cut direction, and reports the nearest point index on
// each side when the last point of the slice arrives.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   point x/y/z (Q12.12), last_point
//   out      out_valid/out_stall positive/negative index and found flag
//   cfg      cfg_we              cfg_idx, cfg_data (center, direction)
//
// One point is taken per cycle while in_stall is low. The last point of
// a slice passes the input, offset, product and sign/sum stages before its
// result enters the queue. Results wait in an eight-entry queue; in_stall
// rises only when queued results plus points in the pipeline fill it.
// Synchronous active-low reset clears the slice state and loads the
// default center and direction.
// ----------------------------------------------------------------------------
module nearest_point_per_side_select #(
  parameter int MAX_POINTS = 1024
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire        [npss_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire        [npss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire signed [npss_pkg::COORD_W-1:0]    in_point_x,
  input  wire signed [npss_pkg::COORD_W-1:0]    in_point_y,
  input  wire signed [npss_pkg::COORD_W-1:0]    in_point_z,
  input  wire                                   in_last_point,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic       [npss_pkg::IDX_W-1:0]      out_positive_index,
  output logic                                  out_positive_found,
  output logic       [npss_pkg::IDX_W-1:0]      out_negative_index,
  output logic                                  out_negative_found
);
  import npss_pkg::*;

  localparam int PEND_W = OQ_CNT_W + 1;

  logic                in_acc;
  npss_pt_t            pt;
  logic [INFL_W-1:0]   inflight;
  logic                res_vld;
  npss_res_t           res;
  npss_res_t           head;
  logic                head_vld;
  logic [OQ_CNT_W-1:0] oq_cnt;
  logic [PEND_W-1:0]   pend;

  // input transfer
  assign in_acc = in_valid && !in_stall;

  // hold off input when every queue slot is spoken for
  assign pend     = PEND_W'(oq_cnt) + PEND_W'(inflight);
  assign in_stall = (pend >= PEND_W'(OQ_DEPTH));

  npss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_acc     (in_acc),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .in_last    (in_last_point),
    .pt         (pt),
    .inflight   (inflight)
  );

  npss_track #(
    .MAX_POINTS (MAX_POINTS)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .pt      (pt),
    .res_vld (res_vld),
    .res     (res)
  );

  npss_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (head_vld && !out_stall),
    .head      (head),
    .head_vld  (head_vld),
    .cnt       (oq_cnt)
  );

  // output channel
  assign out_valid          = head_vld;
  assign out_positive_index = head.pos_idx;
  assign out_positive_found = head.pos_found;
  assign out_negative_index = head.neg_idx;
  assign out_negative_found = head.neg_found;

endmodule
`default_nettype wire

### rtl/core/npss_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_check: port-level checks
// Watches the top level ports for result consistency and output channel
// behavior; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module npss_check (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [npss_pkg::IDX_W-1:0]        out_positive_index,
  input wire                              out_positive_found,
  input wire [npss_pkg::IDX_W-1:0]        out_negative_index,
  input wire                              out_negative_found
);
  import npss_pkg::*;

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid
      && $stable(out_positive_index) && $stable(out_positive_found)
      && $stable(out_negative_index) && $stable(out_negative_found)))
    else $error("stalled result changed");

  // every slice has at least one point, so one side is always found
  a_some_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_positive_found || out_negative_found))
    else $error("result with no side found");

  // a missing side reports index zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_positive_found) |-> (out_positive_index == '0))
    else $error("positive index set without a positive point");

  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_negative_found) |-> (out_negative_index == '0))
    else $error("negative index set without a negative point");

  // reset empties the queue and the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("result or stall present after reset");

endmodule

bind nearest_point_per_side_select npss_check u_npss_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_positive_index (out_positive_index),
  .out_positive_found (out_positive_found),
  .out_negative_index (out_negative_index),
  .out_negative_found (out_negative_found)
);
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: nearest_point_per_side_select
// Streams slices of points through the block and predicts, for each slice,
// the nearest point on either side of the cut plane. A short directed set
// covers one- and two-point slices, ties, zero dot products and register
// extremes. Random slices follow under three idling patterns, then a long
// receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import npss_pkg::*;

  localparam int              SLICE_CAP     = 1024;
  localparam longint unsigned DIST_FAR      = 64'h000F_FFFF_FFFF_FFFF;
  localparam int              SETTLE_CYCLES = 8;
  localparam int              HOLD_CYCLES   = 150;
  localparam int              QUIET_LIMIT   = 2000;
  localparam int              RANDOM_PER_CFG = 85;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    logic                      last;
  } point_t;

  // Slice predictor and queue of expected slice results
  class side_scoreboard;
    logic signed [COORD_W-1:0] ctr_x, ctr_y, ctr_z;
    logic signed [DIR_W-1:0]   dir_x, dir_y, dir_z;
    int unsigned               held;
    longint unsigned           pos_dist, neg_dist;
    int unsigned               pos_idx, neg_idx;
    bit                        pos_have, neg_have, first_pos;
    npss_res_t                 pending[$];
    int                        errors, checked, slices;

    function new();
      ctr_x = '0;
      ctr_y = '0;
      ctr_z = '0;
      dir_x = DIR_X_RST;
      dir_y = '0;
      dir_z = '0;
      errors = 0;
      checked = 0;
      slices = 0;
      clear_slice();
    endfunction

    function void clear_slice();
      held = 0;
      pos_dist = DIST_FAR;
      neg_dist = DIST_FAR;
      pos_idx = 0;
      neg_idx = 0;
      pos_have = 1'b0;
      neg_have = 1'b0;
      first_pos = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_X: ctr_x = data;
        REG_CENTER_Y: ctr_y = data;
        REG_CENTER_Z: ctr_z = data;
        REG_DIR_X:    dir_x = data[DIR_W-1:0];
        REG_DIR_Y:    dir_y = data[DIR_W-1:0];
        REG_DIR_Z:    dir_z = data[DIR_W-1:0];
        default: ;
      endcase
    endfunction

    // Called on each input transfer
    function void note_point(point_t p);
      longint          ox, oy, oz, dot;
      longint unsigned d2;
      npss_res_t       r;
      if (held < SLICE_CAP) begin
        ox = longint'(p.x) - longint'(ctr_x);
        oy = longint'(p.y) - longint'(ctr_y);
        oz = longint'(p.z) - longint'(ctr_z);
        dot = ox * longint'(dir_x) + oy * longint'(dir_y) + oz * longint'(dir_z);
        d2 = ox * ox + oy * oy + oz * oz;
        if (dot > 0) begin
          if (held == 0) first_pos = 1'b1;
          if (d2 < pos_dist) begin
            pos_dist = d2;
            pos_idx = held;
            pos_have = 1'b1;
          end
        end else if (d2 < neg_dist) begin
          // zero dot product lands here too
          neg_dist = d2;
          neg_idx = held;
          neg_have = 1'b1;
        end
        held++;
      end
      if (!p.last) return;
      r.pos_found = 1'b1;
      r.neg_found = 1'b1;
      if (held == 1) begin
        r.pos_idx = '0;
        r.neg_idx = '0;
      end else if (held == 2) begin
        r.pos_idx = first_pos ? IDX_W'(0) : IDX_W'(1);
        r.neg_idx = first_pos ? IDX_W'(1) : IDX_W'(0);
      end else begin
        r.pos_idx = pos_have ? pos_idx[IDX_W-1:0] : '0;
        r.pos_found = pos_have;
        r.neg_idx = neg_have ? neg_idx[IDX_W-1:0] : '0;
        r.neg_found = neg_have;
      end
      pending.push_back(r);
      slices++;
      clear_slice();
    endfunction

    task report(string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
    endtask

    // Called on each output transfer
    task check_result(npss_res_t got);
      npss_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result pos %0d/%0b neg %0d/%0b",
                         got.pos_idx, got.pos_found, got.neg_idx, got.neg_found));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pos_idx !== want.pos_idx)
        report($sformatf("result %0d positive_index %0d, want %0d",
                         checked, got.pos_idx, want.pos_idx));
      if (got.pos_found !== want.pos_found)
        report($sformatf("result %0d positive_found %0b, want %0b",
                         checked, got.pos_found, want.pos_found));
      if (got.neg_idx !== want.neg_idx)
        report($sformatf("result %0d negative_index %0d, want %0d",
                         checked, got.neg_idx, want.neg_idx));
      if (got.neg_found !== want.neg_found)
        report($sformatf("result %0d negative_found %0b, want %0b",
                         checked, got.neg_found, want.neg_found));
    endtask
  endclass

  // DUT signals
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_W-1:0]     in_point_x = '0;
  logic signed [COORD_W-1:0]     in_point_y = '0;
  logic signed [COORD_W-1:0]     in_point_z = '0;
  logic                          in_last_point = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [IDX_W-1:0]              out_positive_index;
  logic                          out_positive_found;
  logic [IDX_W-1:0]              out_negative_index;
  logic                          out_negative_found;

  side_scoreboard sb = new();

  int send_pct = 0;
  int recv_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int points_sent = 0;
  int cfg_settings = 0;

  nearest_point_per_side_select #(.MAX_POINTS(SLICE_CAP)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_point_z         (in_point_z),
    .in_last_point      (in_last_point),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_positive_index (out_positive_index),
    .out_positive_found (out_positive_found),
    .out_negative_index (out_negative_index),
    .out_negative_found (out_negative_found)
  );

  always #1 clk = ~clk;

  // Receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    npss_res_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.pos_idx = out_positive_index;
      seen.pos_found = out_positive_found;
      seen.neg_idx = out_negative_index;
      seen.neg_found = out_negative_found;
      sb.check_result(seen);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL nearest_point_per_side_select");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic point_t pt(int x, int y, int z, bit last);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    p.last = last;
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return {1'b1, {(COORD_W-1){1'b0}}};
    else if (r < 16) return {1'b0, {(COORD_W-1){1'b1}}};
    else return COORD_W'($urandom);
  endfunction

  function automatic logic signed [DIR_W-1:0] rand_dir();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    else if (r < 22) return {1'b1, {(DIR_W-1){1'b0}}};
    else if (r < 32) return {1'b0, {(DIR_W-1){1'b1}}};
    else if (r < 40) return DIR_X_RST;
    else return DIR_W'($urandom);
  endfunction

  // Small signed offset with a random span of up to 2^16
  function automatic int rand_offset();
    int span;
    span = 1 << $urandom_range(16);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Mix of wide random points, points near the center, the center itself,
  // repeats and mirror images of earlier points of the slice
  function automatic point_t random_point(point_t so_far[$]);
    point_t      p, q;
    int unsigned kind;
    kind = $urandom_range(9);
    if (so_far.size() != 0) q = so_far[$urandom_range(so_far.size() - 1)];
    if (kind < 4 || (kind >= 8 && so_far.size() == 0)) begin
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
    end else if (kind < 7) begin
      p.x = sb.ctr_x + COORD_W'(rand_offset());
      p.y = sb.ctr_y + COORD_W'(rand_offset());
      p.z = sb.ctr_z + COORD_W'(rand_offset());
    end else if (kind == 7) begin
      p.x = sb.ctr_x;
      p.y = sb.ctr_y;
      p.z = sb.ctr_z;
    end else if (kind == 8) begin
      p = q;
    end else begin
      p.x = COORD_W'(2 * sb.ctr_x - q.x);
      p.y = COORD_W'(2 * sb.ctr_y - q.y);
      p.z = COORD_W'(2 * sb.ctr_z - q.z);
    end
    p.last = 1'b0;
    return p;
  endfunction

  function automatic int rand_slice_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 1;
    else if (r < 30) return 2;
    else if (r < 90) return $urandom_range(3, 12);
    else return $urandom_range(13, 48);
  endfunction

  task automatic set_idling(int s, int r);
    send_pct = s;
    recv_pct = r;
  endtask

  // Offer one point and hold it until the transfer
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= p.x;
    in_point_y <= p.y;
    in_point_z <= p.z;
    in_last_point <= p.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(p);
    points_sent++;
  endtask

  task automatic send_slice(int n);
    point_t pts[$];
    point_t p;
    for (int i = 0; i < n; i++) begin
      p = random_point(pts);
      p.last = (i == n - 1);
      pts.push_back(p);
      send_point(p);
    end
  endtask

  // Drain all results and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers; direction writes carry junk in the upper bits
  task automatic write_config(int cx, int cy, int cz, int dx, int dy, int dz);
    logic [CFG_IDX_W-1:0]  idx[6];
    logic [CFG_DATA_W-1:0] data[6];
    idx = '{REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z};
    data[0] = CFG_DATA_W'(cx);
    data[1] = CFG_DATA_W'(cy);
    data[2] = CFG_DATA_W'(cz);
    data[3] = {8'($urandom), DIR_W'(dx)};
    data[4] = {8'($urandom), DIR_W'(dy)};
    data[5] = {8'($urandom), DIR_W'(dz)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= data[i];
      @(posedge clk);
      sb.set_reg(idx[i], data[i]);
    end
    cfg_we <= 1'b0;
    cfg_settings++;
  endtask

  task automatic run_random(int target);
    int start;
    start = points_sent;
    while (points_sent - start < target) send_slice(rand_slice_len());
  endtask

  initial begin
    set_idling(37, 50);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset center and direction
    send_point(pt(8388607, 8388607, 8388607, 1'b1));
    send_point(pt(-4096, 0, 0, 1'b0));
    send_point(pt(4096, 0, 0, 1'b1));
    send_point(pt(4096, 0, 0, 1'b0));
    send_point(pt(-8388608, -8388608, -8388608, 1'b1));
    // all positive, tie between the last two
    send_point(pt(300, 0, 0, 1'b0));
    send_point(pt(100, 5, 0, 1'b0));
    send_point(pt(100, -5, 0, 1'b1));
    // zero dot product, tie, then the center itself
    send_point(pt(0, 7, 0, 1'b0));
    send_point(pt(-7, 0, 0, 1'b0));
    send_point(pt(0, 0, 0, 1'b1));
    send_point(pt(-8388608, -8388608, -8388608, 1'b0));
    send_point(pt(-1, -1, -1, 1'b0));
    send_point(pt(-8388608, 8388607, 0, 1'b1));
    settle();

    // Directed: register extremes
    write_config(-8388608, 8388607, -8388608, -32768, 32767, -32768);
    send_point(pt(8388607, -8388608, 8388607, 1'b0));
    send_point(pt(-8388608, 8388607, -8388607, 1'b0));
    send_point(pt(-8388608, 8388607, -8388608, 1'b1));
    settle();
    write_config(8388607, -8388608, 0, -32768, -32768, 32767);
    send_point(pt(-8388608, 8388607, 8388607, 1'b0));
    send_point(pt(8388607, -8388608, -8388608, 1'b0));
    send_point(pt(8388607, -8388608, 0, 1'b0));
    send_point(pt(0, 0, 1, 1'b1));
    settle();

    // Random slices under each idling pattern
    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 0) set_idling(37, 50);
      else if (mode == 1) set_idling(50, 37);
      else set_idling(0, 0);
      for (int k = 0; k < 3; k++) begin
        write_config(rand_coord(), rand_coord(), rand_coord(),
                     rand_dir(), rand_dir(), rand_dir());
        run_random(RANDOM_PER_CFG);
        settle();
      end
    end

    // Receiver holds off while one-point slices keep coming
    hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < 40; i++) send_point(pt(rand_coord(), rand_coord(), rand_coord(), 1'b1));
    settle();

    $display("ran %0d points in %0d slices over %0d register settings, %0d results checked",
             points_sent, sb.slices, cfg_settings, sb.checked);
    $display("covered two idling mixes, full rate and a long receiver hold with input backed up");
    if (sb.errors == 0) begin
      $display("PASS nearest_point_per_side_select");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL nearest_point_per_side_select");
    end
    $finish;
  end

endmodule
